[design/csp_pkg.sv]
// Shared types, constants and the control program of the context symbol predictor.
// Depends on nothing; every other design file imports it.
package csp_pkg;

  // Default configuration of the model
  localparam int unsigned ALPHABET_DEF = 16;
  localparam int unsigned ORDER_DEF    = 2;

  // Fixed field widths
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned STEP_W = 4;

  typedef enum logic [1:0] {
    CMD_PREDICT = 2'd0,
    CMD_UPDATE  = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_IGNORE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_HIST   = 2'd1,
    ST_SYM_RANGE = 2'd2,
    ST_CTX_RANGE = 2'd3
  } status_e;

  // Datapath action selected by one control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_IDLE,
    ACT_CHECK,
    ACT_READ,
    ACT_LOAD,
    ACT_SCAN,
    ACT_PRED,
    ACT_WRITE,
    ACT_CLEAR,
    ACT_RESULT
  } act_e;

  // Branch condition of one control word
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_IS_CLEAR,
    C_SKIP,
    C_IS_UPDATE,
    C_SCAN_MORE,
    C_CLR_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Status flags the datapath hands to the sequencer
  typedef struct packed {
    logic no_accept;
    logic is_clear;
    logic skip;
    logic is_update;
    logic scan_more;
    logic clr_more;
    logic out_busy;
  } cond_flags_t;

  // Program addresses
  localparam logic [STEP_W-1:0] STEP_RESULT = 4'd0;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CHECK  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_BRANCH = 4'd3;
  localparam logic [STEP_W-1:0] STEP_READ   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LOAD   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SCAN   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_PRED   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_WRITE  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_CLR    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_CLRX   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_INIT   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_INITX  = 4'd12;

  // Control store: a branch is taken when its condition holds, else fall through
  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      STEP_RESULT: w = '{ACT_RESULT, C_OUT_BUSY,  STEP_RESULT};
      STEP_IDLE:   w = '{ACT_IDLE,   C_NO_ACCEPT, STEP_IDLE};
      STEP_CHECK:  w = '{ACT_CHECK,  C_IS_CLEAR,  STEP_CLR};
      STEP_BRANCH: w = '{ACT_NONE,   C_SKIP,      STEP_RESULT};
      STEP_READ:   w = '{ACT_READ,   C_NEVER,     STEP_RESULT};
      STEP_LOAD:   w = '{ACT_LOAD,   C_IS_UPDATE, STEP_WRITE};
      STEP_SCAN:   w = '{ACT_SCAN,   C_SCAN_MORE, STEP_SCAN};
      STEP_PRED:   w = '{ACT_PRED,   C_ALWAYS,    STEP_RESULT};
      STEP_WRITE:  w = '{ACT_WRITE,  C_ALWAYS,    STEP_RESULT};
      STEP_CLR:    w = '{ACT_CLEAR,  C_CLR_MORE,  STEP_CLR};
      STEP_CLRX:   w = '{ACT_NONE,   C_ALWAYS,    STEP_RESULT};
      STEP_INIT:   w = '{ACT_CLEAR,  C_CLR_MORE,  STEP_INIT};
      STEP_INITX:  w = '{ACT_NONE,   C_ALWAYS,    STEP_IDLE};
      default:     w = '{ACT_NONE,   C_ALWAYS,    STEP_INIT};
    endcase
    return w;
  endfunction

endpackage

[design/csp_if.sv]
// Valid/ready channel interfaces for the predictor's command and result beats.
// Depends on csp_pkg for field widths.
interface csp_in_if
  import csp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic             history_valid;
  logic [SYM_W-1:0] ctx_newest;
  logic [SYM_W-1:0] ctx_older;
  logic [SYM_W-1:0] symbol;

  modport source (
    output valid, cmd, history_valid, ctx_newest, ctx_older, symbol,
    input  ready
  );
  modport sink (
    input  valid, cmd, history_valid, ctx_newest, ctx_older, symbol,
    output ready
  );
endinterface

interface csp_out_if
  import csp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] prediction;
  logic [1:0]       status;

  modport source (
    output valid, prediction, status,
    input  ready
  );
  modport sink (
    input  valid, prediction, status,
    output ready
  );
endinterface

[design/context_symbol_predictor_top.sv]
// Order-1 or order-2 context predictor: counter table in a row-wide memory, argmax scan per column.
// One item at a time: the next beat is accepted only after the result of the last one loads into the output register.
// Reset: asynchronous, active low; the offset to 0, then a sweep writes the
// identity pattern into every row before the first beat is accepted.
// Depends on csp_pkg, csp_if and csp_sequencer.
module context_symbol_predictor_top
  import csp_pkg::*;
#(
  parameter int unsigned ALPHABET = ALPHABET_DEF,
  parameter int unsigned ORDER    = ORDER_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SYM_W-1:0] cfg_wdata_i,
  csp_in_if.sink           in_i,
  csp_out_if.source        out_o
);

  localparam int unsigned DIG_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned ROWS  = (ORDER >= 2) ? ALPHABET * ALPHABET : ALPHABET;
  localparam int unsigned ROW_W = $clog2(ROWS);

  typedef logic [ALPHABET-1:0][CNT_W-1:0] line_t;

  act_e        act;
  cond_flags_t flags;

  // Configuration and sweep counters
  logic [SYM_W-1:0] offset_q;
  logic [ROW_W-1:0] clr_q;
  logic [DIG_W-1:0] clr_col_q;

  // Latched command beat
  cmd_e             cmd_q;
  logic             hist_q;
  logic [SYM_W-1:0] newest_q, older_q, symbol_q;

  // Checked item
  status_e          status_q, status_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [DIG_W-1:0] sym_q;

  // Scan state
  line_t            rdata_q;
  logic [CNT_W-1:0] best_q;
  logic [DIG_W-1:0] pos_q, col_q;
  logic [SYM_W-1:0] pred_q;

  // Output register
  logic             out_valid_q;
  logic [SYM_W-1:0] out_pred_q;
  status_e          out_status_q;
  logic             out_load;

  // Counter memory
  line_t            table_mem [ROWS];
  logic             mem_we;
  logic [ROW_W-1:0] mem_waddr;
  line_t            mem_wdata, upd_line, init_line;

  csp_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .act_o   (act)
  );

  // Digit range checks against the offset
  logic [SYM_W-1:0] d_new, d_old, d_sym;
  logic             new_ok, old_ok, sym_ok, ctx_ok;

  assign d_new  = newest_q - offset_q;
  assign d_old  = older_q - offset_q;
  assign d_sym  = symbol_q - offset_q;
  assign new_ok = (newest_q >= offset_q) && ({1'b0, d_new} < (SYM_W+1)'(ALPHABET));
  assign old_ok = (ORDER < 2) ||
                  ((older_q >= offset_q) && ({1'b0, d_old} < (SYM_W+1)'(ALPHABET)));
  assign sym_ok = (symbol_q >= offset_q) && ({1'b0, d_sym} < (SYM_W+1)'(ALPHABET));
  assign ctx_ok = new_ok && old_ok;

  // Row index from context digits
  always_comb begin
    if (ORDER >= 2) begin
      row_d = ROW_W'(d_new[DIG_W-1:0]) + ROW_W'(d_old[DIG_W-1:0]) * ROW_W'(ALPHABET);
    end else begin
      row_d = ROW_W'(d_new[DIG_W-1:0]);
    end
  end

  // Status in check order of each command
  always_comb begin
    status_d = ST_OK;
    if (cmd_q == CMD_PREDICT) begin
      priority if (!hist_q) status_d = ST_NO_HIST;
      else if (!ctx_ok)     status_d = ST_CTX_RANGE;
      else                  status_d = ST_OK;
    end else if (cmd_q == CMD_UPDATE) begin
      priority if (!sym_ok) status_d = ST_SYM_RANGE;
      else if (!hist_q)     status_d = ST_NO_HIST;
      else if (!ctx_ok)     status_d = ST_CTX_RANGE;
      else                  status_d = ST_OK;
    end
  end

  // Saturating increment of the observed column; identity row for the sweep
  always_comb begin
    for (int unsigned c = 0; c < ALPHABET; c++) begin
      if (DIG_W'(c) == sym_q && rdata_q[c] != '1) begin
        upd_line[c] = rdata_q[c] + CNT_W'(1);
      end else begin
        upd_line[c] = rdata_q[c];
      end
      init_line[c] = (DIG_W'(c) == clr_col_q) ? CNT_W'(1) : '0;
    end
  end

  assign mem_we    = (act == ACT_WRITE) || (act == ACT_CLEAR);
  assign mem_waddr = (act == ACT_CLEAR) ? clr_q : row_q;
  assign mem_wdata = (act == ACT_CLEAR) ? init_line : upd_line;

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (act == ACT_READ) begin
      rdata_q <= table_mem[row_q];
    end
  end

  // Handshake and branch flags
  assign in_i.ready = (act == ACT_IDLE);
  assign out_load   = (act == ACT_RESULT) && (!out_valid_q || out_o.ready);

  assign flags.no_accept = !in_i.valid;
  assign flags.is_clear  = (cmd_q == CMD_CLEAR);
  assign flags.skip      = (status_q != ST_OK) || (cmd_q == CMD_IGNORE);
  assign flags.is_update = (cmd_q == CMD_UPDATE);
  assign flags.scan_more = (col_q != DIG_W'(ALPHABET - 1));
  assign flags.clr_more  = (clr_q != ROW_W'(ROWS - 1));
  assign flags.out_busy  = out_valid_q && !out_o.ready;

  // Control state: offset, sweep counters, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      clr_q       <= '0;
      clr_col_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      if (act == ACT_CLEAR) begin
        clr_q     <= flags.clr_more ? clr_q + ROW_W'(1) : '0;
        clr_col_q <= (clr_col_q == DIG_W'(ALPHABET - 1)) ? '0 : clr_col_q + DIG_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q    <= cmd_e'(in_i.cmd);
      hist_q   <= in_i.history_valid;
      newest_q <= in_i.ctx_newest;
      older_q  <= in_i.ctx_older;
      symbol_q <= in_i.symbol;
    end
    unique case (act)
      ACT_CHECK: begin
        status_q <= status_d;
        row_q    <= row_d;
        sym_q    <= d_sym[DIG_W-1:0];
        pred_q   <= '0;
      end
      ACT_LOAD: begin
        best_q <= rdata_q[0];
        pos_q  <= '0;
        col_q  <= DIG_W'(1);
      end
      ACT_SCAN: begin
        if (rdata_q[col_q] > best_q) begin
          best_q <= rdata_q[col_q];
          pos_q  <= col_q;
        end
        col_q <= col_q + DIG_W'(1);
      end
      ACT_PRED: begin
        pred_q <= SYM_W'(pos_q) + offset_q;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_pred_q   <= pred_q;
      out_status_q <= status_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.prediction = out_pred_q;
  assign out_o.status     = out_status_q;

  // No table write while a beat can be accepted
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !mem_we)
    else $error("table written while idle");
  // Counter update only for a checked update command
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act == ACT_WRITE |-> status_q == ST_OK && cmd_q == CMD_UPDATE)
    else $error("counter written for a failed or foreign command");
  // Failed items never carry a prediction
  a_err_pred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (status_q == ST_OK || pred_q == '0))
    else $error("nonzero prediction on an error result");
  // Sweep row and column counters stay aligned
  a_sweep_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q == '0 |-> clr_col_q == '0)
    else $error("identity sweep column out of step with row");

endmodule

[design/csp_sequencer.sv]
// Microcode sequencer: step counter, control store lookup and conditional branch.
// Depends on csp_pkg for the control word format and the program.
module csp_sequencer
  import csp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cond_flags_t flags_i,
  output act_e        act_o
);

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            word;
  logic              take;

  assign word  = ucode_rom(step_q);
  assign act_o = word.act;

  // Evaluate the branch condition of the current word
  always_comb begin
    unique case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_ACCEPT: take = flags_i.no_accept;
      C_IS_CLEAR:  take = flags_i.is_clear;
      C_SKIP:      take = flags_i.skip;
      C_IS_UPDATE: take = flags_i.is_update;
      C_SCAN_MORE: take = flags_i.scan_more;
      C_CLR_MORE:  take = flags_i.clr_more;
      C_OUT_BUSY:  take = flags_i.out_busy;
      default:     take = 1'b1;
    endcase
  end

  assign step_d = take ? word.target : step_q + STEP_W'(1);

  // Advance the step counter; start with the table sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_INIT;
    end else begin
      step_q <= step_d;
    end
  end

  // Reset leaves the program at the initial sweep
  a_reset_start: assert property (@(posedge clk_i) $rose(rst_ni) |-> step_q == STEP_INIT)
    else $error("sequencer did not start at the table sweep");
  // A read is always followed by the load of its data
  a_read_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_o == ACT_READ |=> act_o == ACT_LOAD)
    else $error("memory read not followed by load");
  // Result step either waits or falls into idle
  a_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_o == ACT_RESULT |=> act_o == ACT_RESULT || act_o == ACT_IDLE)
    else $error("result step left to a wrong step");

endmodule

[bench/tb_context_symbol_predictor_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for context_symbol_predictor_top: drives command beats and keeps its
// own count table to work out each prediction/status beat, compared in order of arrival.
// Depends on csp_pkg, csp_if (csp_in_if, csp_out_if) and the design top.
module tb_context_symbol_predictor_top;
  import csp_pkg::*;

  localparam int unsigned ALPH          = ALPHABET_DEF;
  localparam int unsigned ORD           = ORDER_DEF;
  localparam int unsigned ROWS          = ALPH * ALPH;
  localparam int unsigned SETTLE_CYCLES = ROWS + 40;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  // One entry of the stimulus list: a command beat or a register write
  typedef struct {
    bit               is_cfg;
    logic [SYM_W-1:0] cfg_val;
    int unsigned      idle_max;
    int unsigned      gap;
    cmd_e             cmd;
    logic             hist;
    logic [SYM_W-1:0] newest;
    logic [SYM_W-1:0] older;
    logic [SYM_W-1:0] sym;
  } cmd_beat_t;

  typedef struct {
    logic [SYM_W-1:0] prediction;
    status_e          status;
  } pred_beat_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [SYM_W-1:0] cfg_wdata;

  csp_in_if  cmd_bus ();
  csp_out_if res_bus ();

  context_symbol_predictor_top #(
    .ALPHABET (ALPH),
    .ORDER    (ORD)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (cmd_bus),
    .out_o       (res_bus)
  );

  // Bench copy of the counter table and the offset register
  bit   [CNT_W-1:0] freq_tab [ROWS][ALPH];
  logic [SYM_W-1:0] sym_offset = '0;

  cmd_beat_t   beat_q[$];
  cmd_beat_t   cur_beat;
  pred_beat_t  pred_q[$];
  int unsigned fill_gap_max = 16;
  int unsigned stall_max    = 16;
  int unsigned wait_cnt     = 0;
  int unsigned stall_cnt    = 0;
  int unsigned mismatch_cnt = 0;

  // Identity pattern: row r counts one for column r mod ALPH, zero elsewhere
  function automatic void load_identity();
    int unsigned used_rows;
    used_rows = (ORD >= 2) ? ROWS : ALPH;
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < ALPH; c++)
        freq_tab[r][c] = (r < used_rows && c == r % ALPH) ? 16'd1 : 16'd0;
  endfunction

  function automatic bit sym_to_digit(input logic [SYM_W-1:0] s, output int unsigned d);
    d = 0;
    if (s < sym_offset || (s - sym_offset) >= ALPH) return 1'b0;
    d = s - sym_offset;
    return 1'b1;
  endfunction

  // Newest symbol is the low digit; the older one only counts from order two up
  function automatic bit ctx_to_row(input logic [SYM_W-1:0] newest, input logic [SYM_W-1:0] older,
                                    output int unsigned row);
    int unsigned d0, d1;
    d1  = 0;
    row = 0;
    if (!sym_to_digit(newest, d0)) return 1'b0;
    if (ORD >= 2 && !sym_to_digit(older, d1)) return 1'b0;
    row = d0 + d1 * ALPH;
    return 1'b1;
  endfunction

  // Work out the result beat of one command and apply it to the table
  function automatic pred_beat_t predict_and_count(cmd_beat_t b);
    pred_beat_t  r;
    int unsigned row, sd, best;
    r.prediction = '0;
    r.status     = ST_OK;
    case (b.cmd)
      CMD_PREDICT: begin
        if (!b.hist) begin
          r.status = ST_NO_HIST;
        end else if (!ctx_to_row(b.newest, b.older, row)) begin
          r.status = ST_CTX_RANGE;
        end else begin
          // Lowest column wins a tie
          best = 0;
          for (int c = 1; c < ALPH; c++)
            if (freq_tab[row][c] > freq_tab[row][best]) best = c;
          r.prediction = SYM_W'(best + sym_offset);
        end
      end
      CMD_UPDATE: begin
        if (!sym_to_digit(b.sym, sd)) r.status = ST_SYM_RANGE;
        else if (!b.hist) r.status = ST_NO_HIST;
        else if (!ctx_to_row(b.newest, b.older, row)) r.status = ST_CTX_RANGE;
        else if (freq_tab[row][sd] != CNT_MAX) freq_tab[row][sd]++;
      end
      CMD_CLEAR: begin
        load_identity();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic add_beat(cmd_e c, logic h, logic [SYM_W-1:0] nw, logic [SYM_W-1:0] od,
                          logic [SYM_W-1:0] sy);
    cmd_beat_t b;
    b.is_cfg   = 1'b0;
    b.cfg_val  = '0;
    b.idle_max = 0;
    b.gap      = $urandom_range(0, fill_gap_max);
    b.cmd      = c;
    b.hist     = h;
    b.newest   = nw;
    b.older    = od;
    b.sym      = sy;
    beat_q.push_back(b);
  endtask

  // Register write that opens a phase; also sets how much both sides idle in it
  task automatic add_cfg(logic [SYM_W-1:0] val, int unsigned idle);
    cmd_beat_t b;
    b.is_cfg     = 1'b1;
    b.cfg_val    = val;
    b.idle_max   = idle;
    b.gap        = 0;
    b.cmd        = CMD_IGNORE;
    b.hist       = 1'b0;
    b.newest     = '0;
    b.older      = '0;
    b.sym        = '0;
    fill_gap_max = idle;
    beat_q.push_back(b);
  endtask

  // Mostly in-range symbols, biased toward a few hot digits, with some full-range noise
  function automatic logic [SYM_W-1:0] pick_symbol(logic [SYM_W-1:0] off, int unsigned hot);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return SYM_W'($urandom_range(0, 255));
    if (roll < 55) return SYM_W'(off + $urandom_range(0, hot - 1));
    return SYM_W'(off + $urandom_range(0, ALPH - 1));
  endfunction

  task automatic add_random(int unsigned n, logic [SYM_W-1:0] off);
    int unsigned roll;
    cmd_e        c;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) c = CMD_PREDICT;
      else if (roll < 88) c = CMD_UPDATE;
      else if (roll < 94) c = CMD_IGNORE;
      else c = CMD_CLEAR;
      add_beat(c, $urandom_range(0, 19) != 0, pick_symbol(off, 4), pick_symbol(off, 2),
               pick_symbol(off, 6));
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reset and known input levels from time zero
  initial begin
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.cmd           = CMD_PREDICT;
    cmd_bus.history_valid = 1'b0;
    cmd_bus.ctx_newest    = '0;
    cmd_bus.ctx_older     = '0;
    cmd_bus.symbol        = '0;
    res_bus.ready         = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: issue register writes when drained, else the next beat after its idle gap
  always @(posedge clk_i) begin
    logic             valid_nxt;
    logic             we_nxt;
    logic [SYM_W-1:0] wdata_nxt;
    if (rst_ni) begin
      valid_nxt = cmd_bus.valid;
      we_nxt    = 1'b0;
      wdata_nxt = cfg_wdata;
      // Beat accepted: its result follows in acceptance order
      if (cmd_bus.valid && cmd_bus.ready) begin
        pred_q.push_back(predict_and_count(cur_beat));
        valid_nxt = 1'b0;
      end
      if (!valid_nxt && beat_q.size() != 0) begin
        if (beat_q[0].is_cfg) begin
          // Hold the write until every result is back
          if (pred_q.size() == 0) begin
            we_nxt     = 1'b1;
            wdata_nxt  = beat_q[0].cfg_val;
            sym_offset = beat_q[0].cfg_val;
            stall_max  = beat_q[0].idle_max;
            void'(beat_q.pop_front());
            wait_cnt = 0;
          end
        end else if (wait_cnt < beat_q[0].gap) begin
          wait_cnt++;
        end else begin
          cur_beat  = beat_q.pop_front();
          wait_cnt  = 0;
          valid_nxt = 1'b1;
          cmd_bus.cmd           <= cur_beat.cmd;
          cmd_bus.history_valid <= cur_beat.hist;
          cmd_bus.ctx_newest    <= cur_beat.newest;
          cmd_bus.ctx_older     <= cur_beat.older;
          cmd_bus.symbol        <= cur_beat.sym;
        end
      end
      cmd_bus.valid <= valid_nxt;
      cfg_we        <= we_nxt;
      cfg_wdata     <= wdata_nxt;
    end
  end

  // Monitor: check each result beat against the oldest prediction, stall at random
  always @(posedge clk_i) begin
    pred_beat_t want;
    logic       ready_nxt;
    if (rst_ni) begin
      ready_nxt = res_bus.ready;
      if (res_bus.valid && res_bus.ready) begin
        if (pred_q.size() == 0) begin
          mismatch_cnt++;
          $error("unexpected result beat: prediction %0d status %0d",
                 res_bus.prediction, res_bus.status);
        end else begin
          want = pred_q.pop_front();
          if (res_bus.prediction !== want.prediction) begin
            mismatch_cnt++;
            $error("prediction: expected %0d, got %0d", want.prediction, res_bus.prediction);
          end
          if (res_bus.status !== want.status) begin
            mismatch_cnt++;
            $error("status: expected %0d, got %0d", want.status, res_bus.status);
          end
        end
        stall_cnt = $urandom_range(0, stall_max);
        if (stall_cnt != 0) ready_nxt = 1'b0;
      end else if (!res_bus.ready) begin
        if (stall_cnt != 0) stall_cnt--;
        if (stall_cnt == 0) ready_nxt = 1'b1;
      end
      res_bus.ready <= ready_nxt;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [SYM_W-1:0] off;
    load_identity();

    // Offset zero: status codes, row extremes, counting, ties, ignore and clear
    add_cfg(8'd0, 16);
    add_beat(CMD_PREDICT, 1'b0, 8'd0, 8'd0, 8'd0);
    add_beat(CMD_PREDICT, 1'b1, 8'd0, 8'd0, 8'd0);
    add_beat(CMD_PREDICT, 1'b1, 8'd15, 8'd15, 8'd0);
    add_beat(CMD_PREDICT, 1'b1, 8'd16, 8'd0, 8'd0);
    add_beat(CMD_PREDICT, 1'b1, 8'd0, 8'd255, 8'd0);
    add_beat(CMD_UPDATE, 1'b0, 8'd200, 8'd0, 8'd16);
    add_beat(CMD_UPDATE, 1'b0, 8'd0, 8'd0, 8'd15);
    add_beat(CMD_UPDATE, 1'b1, 8'd200, 8'd0, 8'd0);
    add_beat(CMD_UPDATE, 1'b1, 8'd3, 8'd2, 8'd9);
    add_beat(CMD_UPDATE, 1'b1, 8'd3, 8'd2, 8'd9);
    add_beat(CMD_PREDICT, 1'b1, 8'd3, 8'd2, 8'd0);
    add_beat(CMD_UPDATE, 1'b1, 8'd4, 8'd0, 8'd2);
    add_beat(CMD_PREDICT, 1'b1, 8'd4, 8'd0, 8'd0);
    add_beat(CMD_IGNORE, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    add_beat(CMD_CLEAR, 1'b1, 8'hAA, 8'h55, 8'hFF);
    add_beat(CMD_PREDICT, 1'b1, 8'd3, 8'd2, 8'd0);

    // Offset at its top: only symbol 255 is in range
    add_cfg(8'd255, 0);
    add_beat(CMD_PREDICT, 1'b1, 8'd255, 8'd255, 8'd0);
    add_beat(CMD_UPDATE, 1'b1, 8'd255, 8'd255, 8'd255);
    add_beat(CMD_PREDICT, 1'b1, 8'd255, 8'd255, 8'd0);
    add_beat(CMD_PREDICT, 1'b1, 8'd0, 8'd255, 8'd0);
    add_beat(CMD_UPDATE, 1'b1, 8'd255, 8'd255, 8'd254);

    // Raise column 12 of row 0, then read it back past the 8-bit wrap
    add_cfg(8'd0, 16);
    repeat (3) add_beat(CMD_UPDATE, 1'b1, 8'd0, 8'd0, 8'd12);
    add_cfg(8'd250, 16);
    add_beat(CMD_PREDICT, 1'b1, 8'd250, 8'd250, 8'd0);
    add_beat(CMD_PREDICT, 1'b1, 8'd255, 8'd250, 8'd0);

    // Random phases, each under its own offset; some with no idling at all
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: off = 8'd0;
        3: off = 8'd255;
        4: off = 8'd241;
        6: off = 8'd1;
        default: off = SYM_W'($urandom_range(0, 255));
      endcase
      add_cfg(off, (p % 3 == 1) ? 0 : 16);
      add_random(150, off);
    end

    @(posedge rst_ni);
    while (beat_q.size() != 0 || cmd_bus.valid || pred_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pred_q.size() != 0) begin
      mismatch_cnt++;
      $error("result beats missing: %0d", pred_q.size());
    end
    if (mismatch_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
